// File: design/assert_macros.svh
// Assertion macros shared by the ARP header parser RTL.
// Depends on nothing; checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/ahp_pkg.sv
// Types and constants of the ARP header parser.
// Used by the front end, the packet queue, the back end and the top level.
package ahp_pkg;

	localparam int COUNTER_BITS_DEF = 11;
	localparam int LEN_BITS = 11;
	localparam int CAP_BITS = 11;
	localparam int WIRE_BITS = 16;

	localparam logic [CAP_BITS-1:0] CAP_MAX = '1;
	localparam logic [LEN_BITS-1:0] FIXED_HDR = 11'd8;

	localparam logic [15:0] FMT_ETHERNET = 16'h0001;
	localparam logic [15:0] FMT_IPV4 = 16'h0800;
	localparam logic [15:0] FMT_IPV6 = 16'h86DD;
	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY = 16'd2;
	localparam logic [7:0] ETH_ALEN = 8'd6;
	localparam logic [7:0] IPV4_ALEN = 8'd4;
	localparam logic [7:0] IPV6_ALEN = 8'd16;

	// Byte offsets inside the fixed header.
	localparam logic [2:0] OFS_HTYPE_HI = 3'd0;
	localparam logic [2:0] OFS_HTYPE_LO = 3'd1;
	localparam logic [2:0] OFS_PTYPE_HI = 3'd2;
	localparam logic [2:0] OFS_PTYPE_LO = 3'd3;
	localparam logic [2:0] OFS_HLEN = 3'd4;
	localparam logic [2:0] OFS_PLEN = 3'd5;
	localparam logic [2:0] OFS_OPER_HI = 3'd6;
	localparam logic [2:0] OFS_OPER_LO = 3'd7;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_MALFORMED = 2'd1,
		STATUS_SHORT = 2'd2
	} status_t;

	// Everything the back end needs to judge one finished packet.
	typedef struct packed {
		logic [15:0] hw_format;
		logic [15:0] proto_format;
		logic [7:0] hw_alen;
		logic [7:0] proto_alen;
		logic [15:0] opcode;
		logic [47:0] mac;
		logic [63:0] sender_hi;
		logic [63:0] sender_lo;
		logic [63:0] target_hi;
		logic [63:0] target_lo;
		logic [CAP_BITS-1:0] cap;
		logic [WIRE_BITS-1:0] wire_size;
	} pkt_rec_t;

endpackage

// File: design/ahp_front.sv
// Front end of the ARP header parser: counts bytes, latches header fields
// and shifts in addresses. Depends on ahp_pkg; feeds ahp_queue.
module ahp_front import ahp_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	output logic byte_ready,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	input  logic [WIRE_BITS-1:0] wire_length,
	output logic rec_valid,
	input  logic rec_ready,
	output pkt_rec_t rec
);

	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
	logic [15:0] hw_fmt_q, hw_fmt_d, pr_fmt_q, pr_fmt_d, oper_q, oper_d;
	logic [7:0] hal_q, hal_d, pal_q, pal_d;
	logic [47:0] mac_q, mac_d;
	logic [63:0] s_hi_q, s_hi_d, s_lo_q, s_lo_d, t_hi_q, t_hi_d, t_lo_q, t_lo_d;
	logic [LEN_BITS-1:0] s_start, s_end, t_start, t_end;
	logic is_ip, is_eth, accept;
	logic in_sender, in_mac, in_target;

	// Only a last byte needs room in the queue; other bytes keep flowing.
	assign byte_ready = rec_ready || !last_byte;
	assign accept = byte_valid && byte_ready;
	assign rec_valid = accept && last_byte;

	assign is_ip = (pr_fmt_q == FMT_IPV4) || (pr_fmt_q == FMT_IPV6);
	assign is_eth = hw_fmt_q == FMT_ETHERNET;

	// Address windows follow the fixed header: sender hw, sender proto,
	// target hw, target proto.
	assign s_start = FIXED_HDR + LEN_BITS'(hal_q);
	assign s_end = s_start + LEN_BITS'(pal_q);
	assign t_start = s_end + LEN_BITS'(hal_q);
	assign t_end = t_start + LEN_BITS'(pal_q);

	assign in_sender = is_ip && cnt_q >= COUNTER_BITS'(s_start) && cnt_q < COUNTER_BITS'(s_end);
	assign in_mac = is_eth && cnt_q >= COUNTER_BITS'(s_end) && cnt_q < COUNTER_BITS'(t_start);
	assign in_target = is_ip && cnt_q >= COUNTER_BITS'(t_start) && cnt_q < COUNTER_BITS'(t_end);

	always_comb begin
		hw_fmt_d = hw_fmt_q;
		pr_fmt_d = pr_fmt_q;
		hal_d = hal_q;
		pal_d = pal_q;
		oper_d = oper_q;
		mac_d = mac_q;
		s_hi_d = s_hi_q;
		s_lo_d = s_lo_q;
		t_hi_d = t_hi_q;
		t_lo_d = t_lo_q;
		if (cnt_q < COUNTER_BITS'(FIXED_HDR)) begin
			unique case (cnt_q[2:0])
				OFS_HTYPE_HI: hw_fmt_d[15:8] = data_byte;
				OFS_HTYPE_LO: hw_fmt_d[7:0] = data_byte;
				OFS_PTYPE_HI: pr_fmt_d[15:8] = data_byte;
				OFS_PTYPE_LO: pr_fmt_d[7:0] = data_byte;
				OFS_HLEN: hal_d = data_byte;
				OFS_PLEN: pal_d = data_byte;
				OFS_OPER_HI: oper_d[15:8] = data_byte;
				OFS_OPER_LO: oper_d[7:0] = data_byte;
				default: ;
			endcase
		end else begin
			if (in_sender) begin
				s_hi_d = {s_hi_q[55:0], s_lo_q[63:56]};
				s_lo_d = {s_lo_q[55:0], data_byte};
			end
			if (in_mac) begin
				mac_d = {mac_q[39:0], data_byte};
			end
			if (in_target) begin
				t_hi_d = {t_hi_q[55:0], t_lo_q[63:56]};
				t_lo_d = {t_lo_q[55:0], data_byte};
			end
		end
		cnt_d = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	end

	// The captured count only matters against values below 2048, so a wider
	// counter is clamped for the record.
	always_comb begin
		rec.hw_format = hw_fmt_d;
		rec.proto_format = pr_fmt_d;
		rec.hw_alen = hal_d;
		rec.proto_alen = pal_d;
		rec.opcode = oper_d;
		rec.mac = mac_d;
		rec.sender_hi = s_hi_d;
		rec.sender_lo = s_lo_d;
		rec.target_hi = t_hi_d;
		rec.target_lo = t_lo_d;
		rec.wire_size = wire_length;
		if (cnt_d > COUNTER_BITS'(CAP_MAX)) begin
			rec.cap = CAP_MAX;
		end else begin
			rec.cap = cnt_d[CAP_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hw_fmt_q <= '0;
			pr_fmt_q <= '0;
			hal_q <= '0;
			pal_q <= '0;
			oper_q <= '0;
			mac_q <= '0;
			s_hi_q <= '0;
			s_lo_q <= '0;
			t_hi_q <= '0;
			t_lo_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				cnt_q <= '0;
				hw_fmt_q <= '0;
				pr_fmt_q <= '0;
				hal_q <= '0;
				pal_q <= '0;
				oper_q <= '0;
				mac_q <= '0;
				s_hi_q <= '0;
				s_lo_q <= '0;
				t_hi_q <= '0;
				t_lo_q <= '0;
			end else begin
				cnt_q <= cnt_d;
				hw_fmt_q <= hw_fmt_d;
				pr_fmt_q <= pr_fmt_d;
				hal_q <= hal_d;
				pal_q <= pal_d;
				oper_q <= oper_d;
				mac_q <= mac_d;
				s_hi_q <= s_hi_d;
				s_lo_q <= s_lo_d;
				t_hi_q <= t_hi_d;
				t_lo_q <= t_lo_d;
			end
		end
	end

endmodule

// File: design/ahp_queue.sv
// Two-entry queue of finished packet records between front and back end.
// Depends on ahp_pkg.
module ahp_queue import ahp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  pkt_rec_t wr_rec,
	output logic rd_valid,
	input  logic rd_ready,
	output pkt_rec_t rd_rec
);

	pkt_rec_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic push, pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/ahp_back.sv
// Back end of the ARP header parser: checks one packet record and loads
// the result register. Depends on ahp_pkg; fed by ahp_queue.
module ahp_back import ahp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic rec_valid,
	output logic rec_ready,
	input  pkt_rec_t rec,
	output logic result_valid,
	input  logic result_ready,
	output logic [1:0] status,
	output logic [15:0] op_code,
	output logic proto_is_ip,
	output logic proto_is_v6,
	output logic hw_is_eth,
	output logic [47:0] target_mac,
	output logic [63:0] sender_ip_hi,
	output logic [63:0] sender_ip_lo,
	output logic [63:0] target_ip_hi,
	output logic [63:0] target_ip_lo,
	output logic [LEN_BITS-1:0] header_length,
	output logic [WIRE_BITS-1:0] payload_length
);

	logic valid_q;
	logic load;
	logic [LEN_BITS-1:0] msg;
	status_t st;

	assign rec_ready = !valid_q || result_ready;
	assign load = rec_valid && rec_ready;
	assign result_valid = valid_q;

	assign msg = FIXED_HDR + LEN_BITS'({rec.hw_alen, 1'b0}) + LEN_BITS'({rec.proto_alen, 1'b0});

	always_comb begin
		priority if (rec.wire_size < WIRE_BITS'(FIXED_HDR)) begin
			st = STATUS_MALFORMED;
		end else if (rec.cap < CAP_BITS'(FIXED_HDR)) begin
			st = STATUS_SHORT;
		end else if (rec.wire_size < WIRE_BITS'(msg)) begin
			st = STATUS_MALFORMED;
		end else if (rec.cap < CAP_BITS'(msg)) begin
			st = STATUS_SHORT;
		end else if (rec.hw_format == FMT_ETHERNET && rec.hw_alen != ETH_ALEN) begin
			st = STATUS_MALFORMED;
		end else if (rec.proto_format == FMT_IPV4 && rec.proto_alen != IPV4_ALEN) begin
			st = STATUS_MALFORMED;
		end else if (rec.proto_format == FMT_IPV6 && rec.proto_alen != IPV6_ALEN) begin
			st = STATUS_MALFORMED;
		end else if (rec.opcode != OP_REQUEST && rec.opcode != OP_REPLY) begin
			st = STATUS_MALFORMED;
		end else begin
			st = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_ready) begin
			valid_q <= rec_valid;
		end
	end

	// A failed packet reports only its status; every other field is zero.
	always_ff @(posedge clk) begin
		if (load) begin
			status <= st;
			if (st == STATUS_OK) begin
				op_code <= rec.opcode;
				proto_is_ip <= (rec.proto_format == FMT_IPV4) || (rec.proto_format == FMT_IPV6);
				proto_is_v6 <= rec.proto_format == FMT_IPV6;
				hw_is_eth <= rec.hw_format == FMT_ETHERNET;
				target_mac <= rec.mac;
				sender_ip_hi <= rec.sender_hi;
				sender_ip_lo <= rec.sender_lo;
				target_ip_hi <= rec.target_hi;
				target_ip_lo <= rec.target_lo;
				header_length <= msg;
				payload_length <= rec.wire_size - WIRE_BITS'(msg);
			end else begin
				op_code <= '0;
				proto_is_ip <= 1'b0;
				proto_is_v6 <= 1'b0;
				hw_is_eth <= 1'b0;
				target_mac <= '0;
				sender_ip_hi <= '0;
				sender_ip_lo <= '0;
				target_ip_hi <= '0;
				target_ip_lo <= '0;
				header_length <= '0;
				payload_length <= '0;
			end
		end
	end

endmodule

// File: design/arp_header_parser_top.sv
// Top level of the ARP header parser.
// Depends on ahp_pkg, ahp_front, ahp_queue, ahp_back and assert_macros.svh.
`include "assert_macros.svh"

// The parser takes one ARP payload byte per cycle, with last_byte marking
// the final captured byte and wire_length giving the on-wire size. Each
// packet yields exactly one result transaction, passed from the queue to
// the result register when the output is free. The sustained rate is one
// byte per clock while byte_ready is high; the byte counter and its address
// window compares set that path. A two-entry queue of packet records
// decouples the byte front end from the checking back end, so byte_ready
// drops only when both entries are taken and a last byte has nowhere to
// go. Failed packets report their status with all other fields zero.
module arp_header_parser_top import ahp_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	output logic byte_ready,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	input  logic [WIRE_BITS-1:0] wire_length,
	output logic result_valid,
	input  logic result_ready,
	output logic [1:0] status,
	output logic [15:0] op_code,
	output logic proto_is_ip,
	output logic proto_is_v6,
	output logic hw_is_eth,
	output logic [47:0] target_mac,
	output logic [63:0] sender_ip_hi,
	output logic [63:0] sender_ip_lo,
	output logic [63:0] target_ip_hi,
	output logic [63:0] target_ip_lo,
	output logic [LEN_BITS-1:0] header_length,
	output logic [WIRE_BITS-1:0] payload_length
);

	logic f_valid, f_ready, q_valid, q_ready;
	pkt_rec_t f_rec, q_rec;

	ahp_front #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.wire_length(wire_length),
		.rec_valid(f_valid),
		.rec_ready(f_ready),
		.rec(f_rec)
	);

	ahp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_rec(f_rec),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_rec(q_rec)
	);

	ahp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(q_valid),
		.rec_ready(q_ready),
		.rec(q_rec),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.op_code(op_code),
		.proto_is_ip(proto_is_ip),
		.proto_is_v6(proto_is_v6),
		.hw_is_eth(hw_is_eth),
		.target_mac(target_mac),
		.sender_ip_hi(sender_ip_hi),
		.sender_ip_lo(sender_ip_lo),
		.target_ip_hi(target_ip_hi),
		.target_ip_lo(target_ip_lo),
		.header_length(header_length),
		.payload_length(payload_length)
	);

	// A finished packet is always waiting in the queue right after its last byte.
	`ASSERT_NEXT(a_last_queued, clk, arst_n, byte_valid && byte_ready && last_byte, q_valid)
	// Failed packets carry nothing but their status.
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, result_valid && status != STATUS_OK, op_code == '0 && header_length == '0 && payload_length == '0 && target_mac == '0)
	// A good packet has a legal opcode and a message of at least the fixed header.
	`ASSERT_IMPLIES(a_ok_sane, clk, arst_n, result_valid && status == STATUS_OK, (op_code == OP_REQUEST || op_code == OP_REPLY) && header_length >= FIXED_HDR)
	`ASSERT_IMPLIES(a_v6_is_ip, clk, arst_n, result_valid && proto_is_v6, proto_is_ip)

endmodule

// File: tb/arp_header_parser_checker.sv
// Scoreboard for the ARP header parser: predicts one result per packet and compares.
// Depends on ahp_pkg. Watches the byte channel and the result channel of the top level.
`timescale 1ns / 1ps

module arp_header_parser_checker import ahp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	input  logic byte_ready,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	input  logic [WIRE_BITS-1:0] wire_length,
	input  logic result_valid,
	input  logic result_ready,
	input  logic [1:0] status,
	input  logic [15:0] op_code,
	input  logic proto_is_ip,
	input  logic proto_is_v6,
	input  logic hw_is_eth,
	input  logic [47:0] target_mac,
	input  logic [63:0] sender_ip_hi,
	input  logic [63:0] sender_ip_lo,
	input  logic [63:0] target_ip_hi,
	input  logic [63:0] target_ip_lo,
	input  logic [LEN_BITS-1:0] header_length,
	input  logic [WIRE_BITS-1:0] payload_length,
	output int fail_count,
	output int results_owed
);

	localparam int COUNT_MAX = (1 << COUNTER_BITS_DEF) - 1;

	typedef struct packed {
		status_t status;
		logic [15:0] op_code;
		logic proto_is_ip;
		logic proto_is_v6;
		logic hw_is_eth;
		logic [47:0] target_mac;
		logic [63:0] sender_hi;
		logic [63:0] sender_lo;
		logic [63:0] target_hi;
		logic [63:0] target_lo;
		logic [LEN_BITS-1:0] header_length;
		logic [WIRE_BITS-1:0] payload_length;
	} arp_result_t;

	arp_result_t parse_results[$];
	int mismatches;

	// Per-packet parse state.
	int byte_pos;
	logic [15:0] hw_fmt;
	logic [15:0] pr_fmt;
	logic [7:0] hw_len;
	logic [7:0] pr_len;
	logic [15:0] opcode;
	logic [63:0] snd_hi;
	logic [63:0] snd_lo;
	logic [47:0] mac_addr;
	logic [63:0] tgt_hi;
	logic [63:0] tgt_lo;

	function automatic void clear_packet();
		byte_pos = 0;
		hw_fmt = '0;
		pr_fmt = '0;
		hw_len = '0;
		pr_len = '0;
		opcode = '0;
		snd_hi = '0;
		snd_lo = '0;
		mac_addr = '0;
		tgt_hi = '0;
		tgt_lo = '0;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic lst,
		input logic [WIRE_BITS-1:0] wire_size);
		int hal;
		int pal;
		int snd_start;
		int mac_start;
		int tgt_start;
		int msg;
		bit is_ip;
		bit is_eth;
		status_t st;
		arp_result_t r;
		hal = hw_len;
		pal = pr_len;
		is_ip = (pr_fmt == FMT_IPV4) || (pr_fmt == FMT_IPV6);
		is_eth = hw_fmt == FMT_ETHERNET;
		snd_start = int'(FIXED_HDR) + hal;
		mac_start = snd_start + pal;
		tgt_start = mac_start + hal;
		case (byte_pos)
			OFS_HTYPE_HI: hw_fmt[15:8] = b;
			OFS_HTYPE_LO: hw_fmt[7:0] = b;
			OFS_PTYPE_HI: pr_fmt[15:8] = b;
			OFS_PTYPE_LO: pr_fmt[7:0] = b;
			OFS_HLEN: hw_len = b;
			OFS_PLEN: pr_len = b;
			OFS_OPER_HI: opcode[15:8] = b;
			OFS_OPER_LO: opcode[7:0] = b;
			default: begin
				if (is_ip && byte_pos >= snd_start && byte_pos < snd_start + pal)
					{snd_hi, snd_lo} = {snd_hi[55:0], snd_lo, b};
				if (is_eth && byte_pos >= mac_start && byte_pos < mac_start + hal)
					mac_addr = {mac_addr[39:0], b};
				if (is_ip && byte_pos >= tgt_start && byte_pos < tgt_start + pal)
					{tgt_hi, tgt_lo} = {tgt_hi[55:0], tgt_lo, b};
			end
		endcase
		if (byte_pos < COUNT_MAX)
			byte_pos++;
		if (!lst)
			return;

		msg = int'(FIXED_HDR) + 2 * int'(hw_len) + 2 * int'(pr_len);
		st = STATUS_OK;
		if (wire_size < FIXED_HDR)
			st = STATUS_MALFORMED;
		else if (byte_pos < int'(FIXED_HDR))
			st = STATUS_SHORT;
		else if (int'(wire_size) < msg)
			st = STATUS_MALFORMED;
		else if (byte_pos < msg)
			st = STATUS_SHORT;
		else if (hw_fmt == FMT_ETHERNET && hw_len != ETH_ALEN)
			st = STATUS_MALFORMED;
		else if (pr_fmt == FMT_IPV4 && pr_len != IPV4_ALEN)
			st = STATUS_MALFORMED;
		else if (pr_fmt == FMT_IPV6 && pr_len != IPV6_ALEN)
			st = STATUS_MALFORMED;
		else if (opcode != OP_REQUEST && opcode != OP_REPLY)
			st = STATUS_MALFORMED;

		r = '0;
		r.status = st;
		if (st == STATUS_OK) begin
			r.op_code = opcode;
			r.proto_is_ip = is_ip;
			r.proto_is_v6 = pr_fmt == FMT_IPV6;
			r.hw_is_eth = is_eth;
			r.target_mac = mac_addr;
			r.sender_hi = snd_hi;
			r.sender_lo = snd_lo;
			r.target_hi = tgt_hi;
			r.target_lo = tgt_lo;
			r.header_length = LEN_BITS'(msg);
			r.payload_length = WIRE_BITS'(int'(wire_size) - msg);
		end
		parse_results.push_back(r);
		clear_packet();
	endfunction

	function automatic void compare_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_result();
		arp_result_t w;
		if (parse_results.size() == 0) begin
			$display("%0t: result transaction with no packet pending, status %0h",
				$time, status);
			mismatches++;
			return;
		end
		w = parse_results.pop_front();
		compare_field("status", 64'(w.status), 64'(status));
		compare_field("op_code", 64'(w.op_code), 64'(op_code));
		compare_field("proto_is_ip", 64'(w.proto_is_ip), 64'(proto_is_ip));
		compare_field("proto_is_v6", 64'(w.proto_is_v6), 64'(proto_is_v6));
		compare_field("hw_is_eth", 64'(w.hw_is_eth), 64'(hw_is_eth));
		compare_field("target_mac", 64'(w.target_mac), 64'(target_mac));
		compare_field("sender_ip_hi", w.sender_hi, sender_ip_hi);
		compare_field("sender_ip_lo", w.sender_lo, sender_ip_lo);
		compare_field("target_ip_hi", w.target_hi, target_ip_hi);
		compare_field("target_ip_lo", w.target_lo, target_ip_lo);
		compare_field("header_length", 64'(w.header_length), 64'(header_length));
		compare_field("payload_length", 64'(w.payload_length), 64'(payload_length));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_packet();
			parse_results.delete();
			mismatches = 0;
			fail_count <= 0;
			results_owed <= 0;
		end else begin
			if (byte_valid && byte_ready)
				parse_byte(data_byte, last_byte, wire_length);
			if (result_valid && result_ready)
				check_result();
			fail_count <= mismatches;
			results_owed <= parse_results.size();
		end
	end

endmodule

// File: tb/arp_header_parser_top_tb.sv
// Testbench top for the ARP header parser: clock, reset, packet stimulus and verdict.
// Depends on ahp_pkg, arp_header_parser_top and arp_header_parser_checker.
`timescale 1ns / 1ps

module arp_header_parser_top_tb;
	import ahp_pkg::*;

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_ready;
	logic [7:0] data_byte;
	logic last_byte;
	logic [WIRE_BITS-1:0] wire_length;
	logic result_valid;
	logic result_ready;
	logic [1:0] status;
	logic [15:0] op_code;
	logic proto_is_ip;
	logic proto_is_v6;
	logic hw_is_eth;
	logic [47:0] target_mac;
	logic [63:0] sender_ip_hi;
	logic [63:0] sender_ip_lo;
	logic [63:0] target_ip_hi;
	logic [63:0] target_ip_lo;
	logic [LEN_BITS-1:0] header_length;
	logic [WIRE_BITS-1:0] payload_length;
	int fail_count;
	int results_owed;

	logic [7:0] pkt_bytes[$];
	bit quiet;
	int bytes_sent;

	arp_header_parser_top i_dut (.*);

	arp_header_parser_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// The result side draws a stall for every transaction unless quiet is set.
	initial begin
		int stall;
		result_ready = 1'b0;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				@(negedge clk);
				result_ready <= 1'b0;
			end
			@(negedge clk);
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
		end
	end

	// Fixed header followed by random address bytes and optional trailing bytes.
	task automatic make_packet(input logic [15:0] hf, input logic [15:0] pf,
		input logic [7:0] hl, input logic [7:0] pl, input logic [15:0] op, input int extra);
		pkt_bytes.delete();
		pkt_bytes.push_back(hf[15:8]);
		pkt_bytes.push_back(hf[7:0]);
		pkt_bytes.push_back(pf[15:8]);
		pkt_bytes.push_back(pf[7:0]);
		pkt_bytes.push_back(hl);
		pkt_bytes.push_back(pl);
		pkt_bytes.push_back(op[15:8]);
		pkt_bytes.push_back(op[7:0]);
		repeat (2 * int'(hl) + 2 * int'(pl) + extra)
			pkt_bytes.push_back(8'($urandom));
	endtask

	task automatic send_packet(input logic [WIRE_BITS-1:0] wl);
		int gap;
		foreach (pkt_bytes[i]) begin
			gap = quiet ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				@(negedge clk);
				byte_valid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
			@(negedge clk);
			byte_valid <= 1'b1;
			data_byte <= pkt_bytes[i];
			last_byte <= (i == pkt_bytes.size() - 1);
			wire_length <= wl;
			@(posedge clk);
			while (!byte_ready)
				@(posedge clk);
		end
		bytes_sent += pkt_bytes.size();
	endtask

	// Hold off the byte side until every packet has produced its result.
	task automatic drain();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (results_owed != 0)
			@(posedge clk);
	endtask

	initial begin
		int kind;
		int msg;
		int cut;
		int extra;
		int n_pkts;
		bit v6;
		logic [15:0] hf;
		logic [15:0] pf;
		logic [7:0] hl;
		logic [7:0] pl;
		logic [15:0] op;
		logic [WIRE_BITS-1:0] wl;

		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		wire_length = '0;
		quiet = 1'b0;
		bytes_sent = 0;
		n_pkts = 0;
		repeat (2)
			@(negedge clk);
		arst_n = 1'b1;

		// A one-byte packet on a zero-length wire is malformed.
		pkt_bytes.delete();
		pkt_bytes.push_back(8'hFF);
		send_packet('0);
		// Seven captured bytes are too few even on a maximal wire.
		make_packet(FMT_ETHERNET, FMT_IPV4, ETH_ALEN, IPV4_ALEN, OP_REPLY, 0);
		while (pkt_bytes.size() > 7)
			void'(pkt_bytes.pop_back());
		send_packet('1);
		// Header only, unknown formats, zero address lengths: valid with no addresses.
		make_packet(16'hFFFF, 16'h0000, 8'd0, 8'd0, OP_REQUEST, 0);
		send_packet(WIRE_BITS'(8));
		// Ethernet with a zero hardware length and a zero opcode.
		make_packet(FMT_ETHERNET, FMT_IPV4, 8'd0, 8'd0, 16'h0000, 0);
		send_packet(WIRE_BITS'(8));
		drain();

		while (bytes_sent < 1800) begin
			kind = $urandom_range(0, 19);
			quiet = ($urandom_range(0, 3) == 0);
			v6 = $urandom_range(0, 1);
			hf = FMT_ETHERNET;
			hl = ETH_ALEN;
			pf = v6 ? FMT_IPV6 : FMT_IPV4;
			pl = v6 ? IPV6_ALEN : IPV4_ALEN;
			op = $urandom_range(0, 1) ? OP_REQUEST : OP_REPLY;
			extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
			if (kind == 9)
				op = 16'($urandom);
			if (kind == 14 || kind == 15) begin
				if ($urandom_range(0, 1))
					hl = 8'($urandom_range(0, 10));
				else
					pl = 8'($urandom_range(0, 20));
			end
			if (kind == 16 || kind == 17) begin
				hf = 16'($urandom);
				pf = 16'($urandom);
				hl = 8'($urandom_range(0, 8));
				pl = 8'($urandom_range(0, 8));
				// Now and then address lengths anywhere up to the largest the fields allow.
				if ($urandom_range(0, 9) == 0) begin
					hl = 8'($urandom);
					pl = 8'($urandom);
				end
			end
			if (kind == 19)
				hf = 16'($urandom);
			make_packet(hf, pf, hl, pl, op, extra);
			msg = 8 + 2 * int'(hl) + 2 * int'(pl);
			wl = WIRE_BITS'(msg + $urandom_range(0, 1500));
			if ($urandom_range(0, 7) == 0)
				wl = WIRE_BITS'($urandom_range(msg, 65535));
			if (kind == 10 || kind == 11) begin
				cut = $urandom_range(1, msg - 1);
				while (pkt_bytes.size() > cut)
					void'(pkt_bytes.pop_back());
			end
			if (kind == 12 || kind == 13)
				wl = WIRE_BITS'($urandom_range(0, msg - 1));
			if (kind == 18) begin
				pkt_bytes.delete();
				repeat ($urandom_range(1, 40))
					pkt_bytes.push_back(8'($urandom));
				wl = WIRE_BITS'($urandom);
			end
			send_packet(wl);
			n_pkts++;
			if (n_pkts == 20) begin
				// Long enough to run the byte counter into saturation.
				make_packet(FMT_ETHERNET, FMT_IPV4, ETH_ALEN, IPV4_ALEN, OP_REQUEST,
					2100 - 28);
				send_packet('1);
			end
			if (n_pkts % 8 == 0)
				drain();
		end

		drain();
		repeat (20)
			@(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/ahp_pkg.sv
design/ahp_front.sv
design/ahp_queue.sv
design/ahp_back.sv
design/arp_header_parser_top.sv
tb/arp_header_parser_checker.sv
tb/arp_header_parser_top_tb.sv
